[hdl/khs_pkg.sv]
// ----------------------------------------------------------------------------
// khs_pkg
// Shared types, widths and codes for the key/value heap sorter.
// ----------------------------------------------------------------------------
package khs_pkg;

  localparam int MAX_ELEMS   = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // Buffer address width and a count width that also holds MAX_ELEMS itself
  localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W  = ADDR_W + 1;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] item_key;
    logic [VALUE_WIDTH-1:0]      item_value;
    logic                        item_last;
  } item_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] sorted_key;
    logic [VALUE_WIDTH-1:0]      sorted_value;
    logic                        sorted_last;
  } result_t;

  // One stored key/value pair
  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0]      value;
  } pair_t;

  // Operand selection of the shared key comparator
  typedef enum logic [1:0] {
    CMP_UP,     // parent key below the rising pair
    CMP_CHILD,  // left child key below right child key
    CMP_DOWN    // sinking pair key below the larger child
  } cmp_sel_e;

  typedef struct packed {
    cmp_sel_e                    sel;
    logic signed [KEY_WIDTH-1:0] hold_key;  // pair being sifted
    logic signed [KEY_WIDTH-1:0] cand_key;  // chosen child
    logic signed [KEY_WIDTH-1:0] read_key;  // word just read from the heap
  } cmp_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_GET,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_RD0,
    S_POP_RD1,
    S_POP_WR,
    S_DN_L,
    S_DN_R,
    S_DN_RC,
    S_DN_CMP,
    S_OUT,
    S_DRAIN
  } heap_state_e;

endpackage

[hdl/khs_cmp.sv]
// ----------------------------------------------------------------------------
// khs_cmp
// Shared signed key comparator; selects its operand pair per sift step.
// ----------------------------------------------------------------------------
module khs_cmp
  import khs_pkg::*;
(
  input  cmp_req_t req_i,
  output logic     lt_o
);

  logic signed [KEY_WIDTH-1:0] op_a;
  logic signed [KEY_WIDTH-1:0] op_b;

  // Route the operands for the requested step
  always_comb begin
    unique case (req_i.sel)
      CMP_UP: begin
        op_a = req_i.read_key;
        op_b = req_i.hold_key;
      end
      CMP_CHILD: begin
        op_a = req_i.cand_key;
        op_b = req_i.read_key;
      end
      CMP_DOWN: begin
        op_a = req_i.hold_key;
        op_b = req_i.cand_key;
      end
      default: begin
        op_a = req_i.hold_key;
        op_b = req_i.cand_key;
      end
    endcase
  end

  assign lt_o = (op_a < op_b);

endmodule

[hdl/khs_buf.sv]
// ----------------------------------------------------------------------------
// khs_buf
// Load buffer: stores incoming pairs, holds the set size and serves the
// pairs in pre-sort order (rotate left by one, then reverse the head).
// ----------------------------------------------------------------------------
module khs_buf
  import khs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  item_t            item_i,
  input  logic [CNT_W-1:0] rd_pos_i,
  output logic [CNT_W-1:0] set_size_o,
  output pair_t            rd_data_o
);

  pair_t            mem [MAX_ELEMS];
  pair_t            rd_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] size_q, size_d;
  logic             room;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] src;

  assign room      = (count_q < CNT_W'(MAX_ELEMS));
  assign count_inc = room ? count_q + CNT_W'(1) : count_q;

  // Count loaded pairs; the last transaction fixes the set size
  always_comb begin
    count_d = count_q;
    size_d  = size_q;
    if (accept_i) begin
      if (item_i.item_last) begin
        size_d  = count_inc;
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      size_q  <= '0;
    end else begin
      count_q <= count_d;
      size_q  <= size_d;
    end
  end

  // Map a pre-sort position to its load slot
  always_comb begin
    if (size_q <= CNT_W'(2)) begin
      src = rd_pos_i;
    end else if (rd_pos_i == size_q - CNT_W'(1)) begin
      src = '0;
    end else if (rd_pos_i + CNT_W'(3) >= size_q) begin
      src = rd_pos_i + CNT_W'(1);
    end else begin
      src = size_q - CNT_W'(3) - rd_pos_i;
    end
  end

  // Store while there is room, read with registered data
  always_ff @(posedge clk_i) begin
    if (accept_i && room) begin
      mem[count_q[ADDR_W-1:0]] <= '{key: item_i.item_key, value: item_i.item_value};
    end
    rd_q <= mem[src[ADDR_W-1:0]];
  end

  assign set_size_o = size_q;
  assign rd_data_o  = rd_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ELEMS))
    else $error("load count above buffer depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.item_last) |=> (count_q == '0) && (size_q != '0))
    else $error("last transaction did not close the set");

endmodule

[hdl/khs_heap.sv]
// ----------------------------------------------------------------------------
// khs_heap
// Heap sequencer: pushes each pair into a max-heap memory, pops it empty
// into ascending order and streams the result out.
// ----------------------------------------------------------------------------
module khs_heap
  import khs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sort_start_i,
  input  logic [CNT_W-1:0] set_size_i,
  input  pair_t            buf_data_i,
  output logic [CNT_W-1:0] buf_pos_o,
  output logic             busy_o,
  output logic             res_valid_o,
  output result_t          res_o
);

  heap_state_e      state_q, state_d;
  pair_t            mem [MAX_ELEMS];
  pair_t            rd_q;
  pair_t            x_q, x_d;     // pair being sifted
  pair_t            c_q, c_d;     // larger child so far
  logic [ADDR_W-1:0] i_q, i_d;    // hole position
  logic [ADDR_W-1:0] ci_q, ci_d;  // larger child position
  logic [CNT_W-1:0] j_q, j_d;     // push / output counter
  logic [CNT_W-1:0] tail_q, tail_d;
  logic             emit_q, emit_d;
  logic             last_q, last_d;

  logic              we;
  logic [ADDR_W-1:0] wa;
  pair_t             wd;
  logic [ADDR_W-1:0] ra;

  logic [ADDR_W-1:0] parent;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  right;
  logic [CNT_W-1:0]  tail_m1;
  logic              push_done;
  cmp_req_t          cmp_req;
  logic              cmp_lt;

  assign parent  = (i_q - ADDR_W'(1)) >> 1;
  assign left    = {i_q, 1'b1};
  assign right   = left + CNT_W'(1);
  assign tail_m1 = tail_q - CNT_W'(1);
  assign push_done = (j_q == set_size_i - CNT_W'(1));

  khs_cmp u_cmp (
    .req_i (cmp_req),
    .lt_o  (cmp_lt)
  );

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    c_d     = c_q;
    i_d     = i_q;
    ci_d    = ci_q;
    j_d     = j_q;
    tail_d  = tail_q;
    emit_d  = 1'b0;
    last_d  = last_q;
    we      = 1'b0;
    wa      = i_q;
    wd      = x_q;
    ra      = '0;
    cmp_req = '{sel: CMP_UP, hold_key: x_q.key, cand_key: c_q.key, read_key: rd_q.key};

    unique case (state_q)
      S_IDLE: begin
        if (sort_start_i) begin
          j_d     = '0;
          tail_d  = '0;
          state_d = S_PUSH_RD;
        end
      end
      S_PUSH_RD: begin
        state_d = S_PUSH_GET;
      end
      S_PUSH_GET: begin
        x_d     = buf_data_i;
        i_d     = j_q[ADDR_W-1:0];
        state_d = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (i_q == '0) begin
          we     = 1'b1;
          tail_d = j_q + CNT_W'(1);
          if (push_done) begin
            state_d = S_POP_RD0;
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = S_PUSH_RD;
          end
        end else begin
          ra      = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_req.sel = CMP_UP;
        we          = 1'b1;
        if (cmp_lt) begin
          // move the parent down into the hole and climb
          wd      = rd_q;
          i_d     = parent;
          state_d = S_UP_CHK;
        end else begin
          tail_d = j_q + CNT_W'(1);
          if (push_done) begin
            state_d = S_POP_RD0;
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = S_PUSH_RD;
          end
        end
      end
      S_POP_RD0: begin
        ra      = tail_m1[ADDR_W-1:0];
        state_d = S_POP_RD1;
      end
      S_POP_RD1: begin
        x_d     = rd_q;
        ra      = '0;
        state_d = S_POP_WR;
      end
      S_POP_WR: begin
        // park the maximum just past the shrunken heap
        we      = 1'b1;
        wa      = tail_m1[ADDR_W-1:0];
        wd      = rd_q;
        tail_d  = tail_m1;
        i_d     = '0;
        state_d = S_DN_L;
      end
      S_DN_L: begin
        if (left >= tail_q) begin
          we = 1'b1;
          if (tail_q == '0) begin
            j_d     = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_POP_RD0;
          end
        end else begin
          ra      = left[ADDR_W-1:0];
          state_d = S_DN_R;
        end
      end
      S_DN_R: begin
        c_d  = rd_q;
        ci_d = left[ADDR_W-1:0];
        if (right < tail_q) begin
          ra      = right[ADDR_W-1:0];
          state_d = S_DN_RC;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_RC: begin
        cmp_req.sel = CMP_CHILD;
        if (cmp_lt) begin
          c_d  = rd_q;
          ci_d = right[ADDR_W-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmp_req.sel = CMP_DOWN;
        we          = 1'b1;
        if (cmp_lt) begin
          // lift the child into the hole and descend
          wd      = c_q;
          i_d     = ci_q;
          state_d = S_DN_L;
        end else if (tail_q == '0) begin
          j_d     = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_POP_RD0;
        end
      end
      S_OUT: begin
        ra     = j_q[ADDR_W-1:0];
        emit_d = 1'b1;
        last_d = push_done;
        if (push_done) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      ci_q    <= '0;
      j_q     <= '0;
      tail_q  <= '0;
      emit_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      ci_q    <= ci_d;
      j_q     <= j_d;
      tail_q  <= tail_d;
      emit_q  <= emit_d;
      last_q  <= last_d;
    end
  end

  // Hold the sifted pair and the chosen child
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    c_q <= c_d;
  end

  // Heap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  assign buf_pos_o   = j_q;
  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = emit_q;
  assign res_o       = '{sorted_key: rd_q.key, sorted_value: rd_q.value, sorted_last: last_q};

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !emit_q)
    else $error("result strobe while idle");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q && last_q) |=> (state_q == S_IDLE))
    else $error("run did not end after final result");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (tail_q <= set_size_i))
    else $error("heap tail beyond set size");

endmodule

[hdl/key_value_heap_sorter_top.sv]
// ----------------------------------------------------------------------------
// key_value_heap_sorter_top
// Collects key/value pairs and emits them sorted by signed key, ascending.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         start && !busy            item_i   (item_t)
// result    out        sorted_valid_o, 1 cycle   sorted_o (result_t)
//
// A pair that is not last is stored as it is taken; busy stays low.
// The last pair starts the sort: each pair is pushed and climbs past every
// smaller parent (up to 6 levels at 64 pairs); each pop parks the maximum
// and sinks the moved pair past each larger child, then the results stream
// out; the single-port heap read sets this pace.
// Results come out back to back, one per cycle, the final one flagged.
// Reset leaves the block idle with no pairs held; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module key_value_heap_sorter_top
  import khs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    sorted_valid_o,
  output result_t sorted_o
);

  logic             accept;
  logic             sort_start;
  logic [CNT_W-1:0] buf_pos;
  logic [CNT_W-1:0] set_size;
  pair_t            buf_data;

  // Take a transaction whenever the sequencer is idle
  assign accept     = start && !busy;
  assign sort_start = accept && item_i.item_last;

  khs_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .rd_pos_i   (buf_pos),
    .set_size_o (set_size),
    .rd_data_o  (buf_data)
  );

  khs_heap u_heap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sort_start_i (sort_start),
    .set_size_i   (set_size),
    .buf_data_i   (buf_data),
    .buf_pos_o    (buf_pos),
    .busy_o       (busy),
    .res_valid_o  (sorted_valid_o),
    .res_o        (sorted_o)
  );

endmodule
